/* rtl/core/lreg_pkg.sv */
// Shared constants, codes and the controller command type of the slot registry guard.
`default_nettype none

package lreg_pkg;

    // Registry size and derived index width.
    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Field widths.
    localparam int ID_W      = 6;
    localparam int MODE_W    = 3;
    localparam int BYTE_W    = 40;
    localparam int FRAC_W    = 17;
    localparam int STAMP_W   = 48;
    localparam int TOTAL_W   = 46;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // The limit is multiplied by the fraction in two halves.
    localparam int MUL_B_W = BYTE_W / 2;
    localparam int PART_W  = FRAC_W + MUL_B_W;
    localparam int PROD_W  = FRAC_W + BYTE_W;

    localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'd65536;
    localparam logic [FRAC_W-1:0] FRAC_RESET = 17'd58982;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_REGISTER   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UNREGISTER = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TOUCH      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SAMPLE     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BUDGET     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR_STAT = 3'd5;

    // Budget check answers.
    localparam logic [STATUS_W-1:0] BUDGET_FITS       = 2'd0;
    localparam logic [STATUS_W-1:0] BUDGET_FITS_EVICT = 2'd1;
    localparam logic [STATUS_W-1:0] BUDGET_NO_FIT     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_USAGE_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_FRC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_EVICT   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              apply;
        logic              mul_en;
        logic              mul_hi;
        logic              scan_en;
        logic [SLOT_W-1:0] scan_idx;
        logic              finish;
    } lreg_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/lreg_ctrl.sv */
// Sequencing state machine of the slot registry guard.
`default_nettype none

module lreg_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    output logic                    done,
    output lreg_pkg::lreg_cmd_t     cmd
);
    import lreg_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_APPLY  = 3'd1;
    localparam logic [2:0] ST_MUL_LO = 3'd2;
    localparam logic [2:0] ST_MUL_HI = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              done_reg, done_next;
    logic              scan_last;

    assign scan_last = (idx_reg == SLOT_W'(SLOT_COUNT - 1));

    // Next state and scan index.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:  state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI:
            begin
                state_next = ST_SCAN;
                idx_next   = '0;
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign done_next = (state_reg == ST_FINISH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    // Command decode.
    always_comb
    begin
        cmd.load     = (state_reg == ST_IDLE) && start;
        cmd.apply    = (state_reg == ST_APPLY);
        cmd.mul_en   = (state_reg == ST_MUL_LO) || (state_reg == ST_MUL_HI);
        cmd.mul_hi   = (state_reg == ST_MUL_HI);
        cmd.scan_en  = (state_reg == ST_SCAN);
        cmd.scan_idx = idx_reg;
        cmd.finish   = (state_reg == ST_FINISH);
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

/* rtl/core/lreg_datapath.sv */
// Slot registry storage, usage statistics, threshold math and victim search.
`default_nettype none

module lreg_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lreg_pkg::lreg_cmd_t            cmd,
    input  wire logic                           cfg_we,
    input  wire logic [lreg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lreg_pkg::BYTE_W-1:0]    cfg_data,
    input  wire logic [lreg_pkg::MODE_W-1:0]    mode,
    input  wire logic [lreg_pkg::ID_W-1:0]      slot_id,
    input  wire logic [lreg_pkg::BYTE_W-1:0]    byte_amount,
    input  wire logic                           can_evict,
    output logic [lreg_pkg::STATUS_W-1:0]       budget_status,
    output logic                                under_pressure,
    output logic                                evict_valid,
    output logic [lreg_pkg::ID_W-1:0]           evict_slot,
    output logic [lreg_pkg::TOTAL_W-1:0]        total_footprint,
    output logic [lreg_pkg::BYTE_W-1:0]         peak_bytes,
    output logic [lreg_pkg::BYTE_W-1:0]         current_bytes
);
    import lreg_pkg::*;

    // Configuration registers.
    logic [BYTE_W-1:0] limit_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic              auto_reg;

    // Latched item.
    logic [MODE_W-1:0] mode_reg;
    logic [ID_W-1:0]   slot_id_reg;
    logic [BYTE_W-1:0] amount_reg;
    logic              can_evict_reg;

    // Registry.
    logic [SLOT_COUNT-1:0] active_reg;
    logic [SLOT_COUNT-1:0] evictable_reg;
    logic [BYTE_W-1:0]     footprint_reg [SLOT_COUNT];
    logic [STAMP_W-1:0]    stamp_reg [SLOT_COUNT];

    logic [STAMP_W-1:0] counter_reg;
    logic [BYTE_W-1:0]  latest_reg;
    logic [BYTE_W-1:0]  highest_reg;

    // Working registers of one item.
    logic              near_full_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] fixed_reg;
    logic              found_reg;
    logic [STAMP_W-1:0] oldest_reg;
    logic [SLOT_W-1:0] victim_reg;
    logic [BYTE_W-1:0] victim_fp_reg;

    // Result registers.
    logic [STATUS_W-1:0] status_out_reg;
    logic                pressure_out_reg;
    logic                evict_out_reg;
    logic [ID_W-1:0]     evict_slot_out_reg;
    logic [TOTAL_W-1:0]  total_out_reg;

    logic              slot_ok;
    logic [SLOT_W-1:0] sidx;
    logic [FRAC_W-1:0] frac_eff;
    logic [MUL_B_W-1:0] mul_b;
    logic [PART_W-1:0] mul_p;
    logic [44:0]       amount_x20;
    logic [44:0]       limit_x19;
    logic              sc_active;
    logic              sc_evictable;
    logic [BYTE_W-1:0] sc_fp;
    logic [STAMP_W-1:0] sc_stamp;
    logic              pressure_now;
    logic              evict_now;
    logic [TOTAL_W:0]  need_all;
    logic [TOTAL_W:0]  need_fixed;
    logic [STATUS_W-1:0] status_now;

    assign slot_ok = ({1'b0, slot_id_reg} < (ID_W + 1)'(SLOT_COUNT));
    assign sidx    = slot_id_reg[SLOT_W-1:0];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
            frac_reg  <= FRAC_RESET;
            auto_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_USAGE_LIMIT:  limit_reg <= cfg_data;
                CFG_PRESSURE_FRC: frac_reg  <= cfg_data[FRAC_W-1:0];
                CFG_AUTO_EVICT:   auto_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg      <= mode;
            slot_id_reg   <= slot_id;
            amount_reg    <= byte_amount;
            can_evict_reg <= can_evict;
        end
    end

    // Valid bits of the registry: item update, then eviction at the end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            evictable_reg <= '0;
        end
        else if (cmd.apply && slot_ok)
        begin
            if (mode_reg == MODE_REGISTER)
            begin
                active_reg[sidx]    <= 1'b1;
                evictable_reg[sidx] <= can_evict_reg;
            end
            else if (mode_reg == MODE_UNREGISTER)
            begin
                active_reg[sidx]    <= 1'b0;
                evictable_reg[sidx] <= 1'b0;
            end
        end
        else if (cmd.finish && evict_now)
        begin
            active_reg[victim_reg]    <= 1'b0;
            evictable_reg[victim_reg] <= 1'b0;
        end
    end

    // Footprints and stamps. An inactive slot's entry is never looked at.
    always_ff @(posedge clk)
    begin
        if (cmd.apply && slot_ok)
        begin
            if (mode_reg == MODE_REGISTER)
            begin
                footprint_reg[sidx] <= amount_reg;
                stamp_reg[sidx]     <= counter_reg;
            end
            else if (mode_reg == MODE_UNREGISTER)
            begin
                footprint_reg[sidx] <= '0;
                stamp_reg[sidx]     <= '0;
            end
            else if ((mode_reg == MODE_TOUCH) && active_reg[sidx])
            begin
                stamp_reg[sidx] <= counter_reg;
            end
        end
        else if (cmd.finish && evict_now)
        begin
            footprint_reg[victim_reg] <= '0;
        end
    end

    // Use counter and usage statistics.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            latest_reg  <= '0;
            highest_reg <= '0;
        end
        else if (cmd.apply)
        begin
            if (counter_reg != '1)
            begin
                counter_reg <= counter_reg + 1'b1;
            end
            if (mode_reg == MODE_SAMPLE)
            begin
                latest_reg <= amount_reg;
                if (amount_reg > highest_reg)
                begin
                    highest_reg <= amount_reg;
                end
            end
            else if (mode_reg == MODE_CLEAR_STAT)
            begin
                latest_reg  <= '0;
                highest_reg <= '0;
            end
        end
    end

    // Ninety-five percent test: amount * 20 >= limit * 19, by shifts and adds.
    assign amount_x20 = {1'b0, amount_reg, 4'b0} + {3'b0, amount_reg, 2'b0};
    assign limit_x19  = {1'b0, limit_reg, 4'b0} + {4'b0, limit_reg, 1'b0}
                      + {5'b0, limit_reg};

    // Fraction times limit, one half of the limit per cycle.
    assign frac_eff = (frac_reg > FRAC_ONE) ? FRAC_ONE : frac_reg;
    assign mul_b    = cmd.mul_hi ? limit_reg[BYTE_W-1:MUL_B_W] : limit_reg[MUL_B_W-1:0];
    assign mul_p    = PART_W'(frac_eff) * PART_W'(mul_b);

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            near_full_reg <= (amount_x20 >= limit_x19);
        end
        if (cmd.mul_en)
        begin
            if (cmd.mul_hi)
            begin
                prod_reg <= prod_reg + {mul_p, {MUL_B_W{1'b0}}};
            end
            else
            begin
                prod_reg <= PROD_W'(mul_p);
            end
        end
    end

    // Scan: one slot per cycle for sums and the oldest evictable slot.
    assign sc_active    = active_reg[cmd.scan_idx];
    assign sc_evictable = evictable_reg[cmd.scan_idx];
    assign sc_fp        = footprint_reg[cmd.scan_idx];
    assign sc_stamp     = stamp_reg[cmd.scan_idx];

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            total_reg <= '0;
            fixed_reg <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.scan_en && sc_active)
        begin
            total_reg <= total_reg + TOTAL_W'(sc_fp);
            if (!sc_evictable)
            begin
                fixed_reg <= fixed_reg + TOTAL_W'(sc_fp);
            end
            else if (!found_reg || (sc_stamp < oldest_reg))
            begin
                found_reg     <= 1'b1;
                oldest_reg    <= sc_stamp;
                victim_reg    <= cmd.scan_idx;
                victim_fp_reg <= sc_fp;
            end
        end
    end

    // Final decisions.
    assign pressure_now = (mode_reg == MODE_SAMPLE) && (limit_reg != '0)
                        && (amount_reg != '0) && ({1'b0, amount_reg, 16'b0} >= prod_reg);
    assign evict_now    = pressure_now && auto_reg && near_full_reg && found_reg;

    assign need_all   = {1'b0, total_reg} + (TOTAL_W + 1)'(amount_reg);
    assign need_fixed = {1'b0, fixed_reg} + (TOTAL_W + 1)'(amount_reg);

    always_comb
    begin
        status_now = BUDGET_FITS;
        if ((mode_reg == MODE_BUDGET) && (limit_reg != '0))
        begin
            if (need_all <= (TOTAL_W + 1)'(limit_reg))
            begin
                status_now = BUDGET_FITS;
            end
            else if (need_fixed <= (TOTAL_W + 1)'(limit_reg))
            begin
                status_now = BUDGET_FITS_EVICT;
            end
            else
            begin
                status_now = BUDGET_NO_FIT;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_out_reg     <= status_now;
            pressure_out_reg   <= pressure_now;
            evict_out_reg      <= evict_now;
            evict_slot_out_reg <= evict_now ? ID_W'(victim_reg) : '0;
            total_out_reg      <= evict_now ? (total_reg - TOTAL_W'(victim_fp_reg)) : total_reg;
        end
    end

    assign budget_status   = status_out_reg;
    assign under_pressure  = pressure_out_reg;
    assign evict_valid     = evict_out_reg;
    assign evict_slot      = evict_slot_out_reg;
    assign total_footprint = total_out_reg;
    assign peak_bytes      = highest_reg;
    assign current_bytes   = latest_reg;

endmodule

`default_nettype wire

/* rtl/core/lru_eviction_registry_guard_core.sv */
// Top level of the slot registry guard: controller, datapath and configuration port.
// An accepted item (start high, busy low) enters the apply state; busy stays high through
// it, the low and high multiply states for the pressure threshold, a scan of all registry
// slots and the finish state. done is registered from the finish state, and no item is taken
// while busy. Results cannot be stalled and are held from the done cycle to the next finish.
// Reset (rst_n low, asynchronous) clears registry, counter and statistics, resets config.
`default_nettype none

module lru_eviction_registry_guard_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    output logic                                done,
    input  wire logic [lreg_pkg::MODE_W-1:0]    mode,
    input  wire logic [lreg_pkg::ID_W-1:0]      slot_id,
    input  wire logic [lreg_pkg::BYTE_W-1:0]    byte_amount,
    input  wire logic                           can_evict,
    output logic [lreg_pkg::STATUS_W-1:0]       budget_status,
    output logic                                under_pressure,
    output logic                                evict_valid,
    output logic [lreg_pkg::ID_W-1:0]           evict_slot,
    output logic [lreg_pkg::TOTAL_W-1:0]        total_footprint,
    output logic [lreg_pkg::BYTE_W-1:0]         peak_bytes,
    output logic [lreg_pkg::BYTE_W-1:0]         current_bytes,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lreg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lreg_pkg::BYTE_W-1:0]    cfg_data
);
    import lreg_pkg::*;

    lreg_cmd_t cmd;
    logic      busy_int;
    logic      cfg_we;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    lreg_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start && !busy_int),
        .busy  (busy_int),
        .done  (done),
        .cmd   (cmd)
    );

    lreg_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mode            (mode),
        .slot_id         (slot_id),
        .byte_amount     (byte_amount),
        .can_evict       (can_evict),
        .budget_status   (budget_status),
        .under_pressure  (under_pressure),
        .evict_valid     (evict_valid),
        .evict_slot      (evict_slot),
        .total_footprint (total_footprint),
        .peak_bytes      (peak_bytes),
        .current_bytes   (current_bytes)
    );

    assign busy = busy_int;

endmodule

`default_nettype wire

/* rtl/core/lreg_checker.sv */
// Port-level checks of the slot registry guard and their bind to the top level.
`default_nettype none

module lreg_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic                           busy,
    input  wire logic                           done,
    input  wire logic [lreg_pkg::STATUS_W-1:0]  budget_status,
    input  wire logic                           under_pressure,
    input  wire logic                           evict_valid,
    input  wire logic [lreg_pkg::ID_W-1:0]      evict_slot
);
    import lreg_pkg::*;

    // An accepted item makes the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // Each accepted item is followed by a result strobe.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |-> ##13 done)
        else $error("result strobe missing 13 cycles after acceptance");

    // The result cycle is also a cycle in which a new item can be taken.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("busy high during the result cycle");

    // An eviction only happens under pressure.
    assert property (@(posedge clk) disable iff (!rst_n) (done && evict_valid) |-> under_pressure)
        else $error("eviction reported without pressure");

    // Without an eviction the slot field reads zero and the budget code is legal.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !evict_valid) |-> ((evict_slot == '0) && (budget_status != 2'd3)))
        else $error("bad idle eviction slot or budget code");

endmodule

bind lru_eviction_registry_guard_core lreg_checker u_lreg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .budget_status  (budget_status),
    .under_pressure (under_pressure),
    .evict_valid    (evict_valid),
    .evict_slot     (evict_slot)
);

`default_nettype wire
